// ===== hdl/pmd_pkg.sv =====
// Shared types and constants of the pad matrix debounce and note event block.
package pmd_pkg;

  localparam int COL_W      = 3;
  localparam int ROWBITS_W  = 8;
  localparam int TIME_W     = 32;
  localparam int NOTE_W     = 7;
  localparam int VEL_W      = 7;
  localparam int CHAN_W     = 5;
  localparam int DEB_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAN_NUM    = 4'd0,
    REG_ROOT_NOTE   = 4'd1,
    REG_HOLDOFF     = 4'd2,
    REG_ON_VELOCITY = 4'd3
  } cfg_reg_t;

  localparam logic [CHAN_W-1:0] RST_CHAN_NUM    = 5'd1;
  localparam logic [NOTE_W-1:0] RST_ROOT_NOTE   = 7'd48;
  localparam logic [DEB_W-1:0]  RST_HOLDOFF     = 8'd12;
  localparam logic [VEL_W-1:0]  RST_ON_VELOCITY = 7'd100;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_num;
    logic [NOTE_W-1:0] root_note;
    logic [DEB_W-1:0]  holdoff;
    logic [VEL_W-1:0]  on_velocity;
  } cfg_t;

  // One scanned column as it travels from the front to the back.
  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic [ROWBITS_W-1:0] rows;
    logic [TIME_W-1:0]    now;
  } scan_t;

  typedef struct packed {
    logic              note_on;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [CHAN_W-1:0] channel;
  } event_t;

endpackage

// ===== hdl/pad_matrix_debounce_note_events_core.sv =====
// Top level of the pad matrix debounce block: configuration registers, front and back parts.
//
//   channel   direction  handshake                 contents
//   scan      in         scan_valid / scan_stall   column, row_pressed, now_ms
//   event     out        event_valid / event_stall note_on, note, velocity, channel,
//                                                  last_of_column
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Each accepted column occupies the row sequencer for min(ROW_COUNT, 8) rows, one row
// per cycle while the event output is not stalled, through the single read port of the
// timestamp memory; columns follow each other without a gap.
// Columns with no changing pad still take their row cycles; out-of-range columns take none.
// An event is held back until the next event of its column, or the end of the column,
// shows whether it is the last one; the final event of a column is presented after its last
// row has passed the evaluation stage and the pending slot into the output register.
// Reset is synchronous and active high; it restores the register defaults and marks all
// pads released with a zero timestamp, taking effect at once with no clearing pass.
// A stalled event output freezes the whole back part; the two-entry queue keeps taking
// scans until it is full, and only then is scan_stall raised.
module pad_matrix_debounce_note_events_core #(
  parameter int ROW_COUNT = 8,
  parameter int COL_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              scan_valid,
  output logic                              scan_stall,
  input  logic [pmd_pkg::COL_W-1:0]         column,
  input  logic [pmd_pkg::ROWBITS_W-1:0]     row_pressed,
  input  logic [pmd_pkg::TIME_W-1:0]        now_ms,
  output logic                              event_valid,
  input  logic                              event_stall,
  output logic                              note_on,
  output logic [pmd_pkg::NOTE_W-1:0]        note,
  output logic [pmd_pkg::VEL_W-1:0]         velocity,
  output logic [pmd_pkg::CHAN_W-1:0]        channel,
  output logic                              last_of_column,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pmd_pkg::cfg_t     cfg;
  pmd_pkg::scan_t    scan_in;
  pmd_pkg::scan_t    q_scan;
  logic              q_valid;
  logic              q_pop;
  pmd_pkg::event_t   out_ev;

  // Registers are always writable; writes to an index beyond the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chan_num    <= pmd_pkg::RST_CHAN_NUM;
      cfg.root_note   <= pmd_pkg::RST_ROOT_NOTE;
      cfg.holdoff     <= pmd_pkg::RST_HOLDOFF;
      cfg.on_velocity <= pmd_pkg::RST_ON_VELOCITY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (pmd_pkg::cfg_reg_t'(cfg_index))
        pmd_pkg::REG_CHAN_NUM:    cfg.chan_num    <= cfg_data[pmd_pkg::CHAN_W-1:0];
        pmd_pkg::REG_ROOT_NOTE:   cfg.root_note   <= cfg_data[pmd_pkg::NOTE_W-1:0];
        pmd_pkg::REG_HOLDOFF:     cfg.holdoff     <= cfg_data[pmd_pkg::DEB_W-1:0];
        pmd_pkg::REG_ON_VELOCITY: cfg.on_velocity <= cfg_data[pmd_pkg::VEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign scan_in.col  = column;
  assign scan_in.rows = row_pressed;
  assign scan_in.now  = now_ms;

  // The front accepts every transaction it has room for and queues in-range columns.
  pmd_front #(
    .COL_COUNT (COL_COUNT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .scan_valid (scan_valid),
    .scan_stall (scan_stall),
    .scan_in    (scan_in),
    .q_scan     (q_scan),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  // The back visits the rows of a column, updates pad state and emits events.
  pmd_back #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_scan    (q_scan),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (event_valid),
    .out_stall (event_stall),
    .out_ev    (out_ev),
    .out_last  (last_of_column)
  );

  assign note_on  = out_ev.note_on;
  assign note     = out_ev.note;
  assign velocity = out_ev.velocity;
  assign channel  = out_ev.channel;

endmodule

// ===== hdl/pmd_front.sv =====
// Front part: accepts scan transactions, drops out-of-range columns and queues the rest.
module pmd_front #(
  parameter int COL_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          scan_valid,
  output logic          scan_stall,
  input  pmd_pkg::scan_t scan_in,
  output pmd_pkg::scan_t q_scan,
  output logic          q_valid,
  input  logic          q_pop
);

  localparam int DEPTH = 2;

  pmd_pkg::scan_t entries [DEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           keep;
  logic           pop;
  logic           in_range;

  // A column at or beyond the matrix width causes nothing at all.
  assign in_range   = int'(scan_in.col) < COL_COUNT;
  assign scan_stall = (count == 2'(DEPTH));
  assign accept     = scan_valid && !scan_stall;
  assign keep       = accept && in_range;
  assign q_valid    = (count != 2'd0);
  assign pop        = q_pop && q_valid;
  assign q_scan     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(keep) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      entries[wr_ptr] <= scan_in;
    end
  end

endmodule

// ===== hdl/pmd_back.sv =====
// Back part: walks the rows of each queued column, debounces pads and emits note events.
module pmd_back #(
  parameter int ROW_COUNT = 8,
  parameter int COL_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  pmd_pkg::cfg_t     cfg,
  input  pmd_pkg::scan_t    q_scan,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output pmd_pkg::event_t   out_ev,
  output logic              out_last
);

  localparam int SCAN_ROWS = (ROW_COUNT < 8) ? ROW_COUNT : 8;
  localparam int PADS      = ROW_COUNT * COL_COUNT;
  localparam int PAD_W     = (PADS > 1) ? $clog2(PADS) : 1;
  localparam int ROW_W     = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;

  // Row sequencer.
  logic                        busy;
  logic [ROW_W-1:0]            row;
  logic [PAD_W-1:0]            pad_r;
  logic [SCAN_ROWS-1:0]        rows_sh;
  logic [pmd_pkg::TIME_W-1:0]  now_r;
  logic                        last_row;
  logic                        en;
  logic                        issue;
  logic                        load;

  // Evaluation stage.
  logic                        e_valid;
  logic [PAD_W-1:0]            e_pad;
  logic                        e_level;
  logic [pmd_pkg::TIME_W-1:0]  e_now;
  logic                        e_last;

  // Pad state.
  logic [pmd_pkg::TIME_W-1:0]  tmem [PADS];
  logic [pmd_pkg::TIME_W-1:0]  t_rd;
  logic                        fwd_hit;
  logic [pmd_pkg::TIME_W-1:0]  fwd_time;
  logic [PADS-1:0]             pad_down;
  logic [PADS-1:0]             t_known;

  logic [pmd_pkg::TIME_W-1:0]  t_last;
  logic [pmd_pkg::TIME_W-1:0]  elapsed;
  logic                        fire;
  logic                        endi;
  pmd_pkg::event_t             new_ev;

  // Pending event, held until it is known whether it ends its column.
  logic                        p_valid;
  logic                        p_final;
  pmd_pkg::event_t             p_ev;
  logic                        p_valid_next;
  logic                        p_final_next;
  logic                        take_new;
  logic                        push;
  logic                        push_last;

  assign en       = !out_valid || !out_stall;
  assign last_row = (row == ROW_W'(SCAN_ROWS - 1));
  assign issue    = en && busy;
  assign load     = en && q_valid && (!busy || last_row);
  assign q_pop    = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (issue && last_row) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row     <= '0;
      pad_r   <= PAD_W'(q_scan.col);
      rows_sh <= q_scan.rows[SCAN_ROWS-1:0];
      now_r   <= q_scan.now;
    end else if (issue) begin
      row     <= row + 1'b1;
      pad_r   <= pad_r + PAD_W'(COL_COUNT);
      rows_sh <= rows_sh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_pad   <= pad_r;
      e_level <= rows_sh[0];
      e_now   <= now_r;
      e_last  <= last_row;
    end
  end

  // Timestamp memory: read for the issued row while the previous row writes back.
  always_ff @(posedge clk) begin
    if (fire) begin
      tmem[e_pad] <= e_now;
    end
    if (issue) begin
      t_rd     <= tmem[pad_r];
      fwd_hit  <= fire && (e_pad == pad_r);
      fwd_time <= e_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_down <= '0;
      t_known  <= '0;
    end else if (fire) begin
      pad_down[e_pad] <= e_level;
      t_known[e_pad]  <= 1'b1;
    end
  end

  always_comb begin
    if (fwd_hit) begin
      t_last = fwd_time;
    end else if (t_known[e_pad]) begin
      t_last = t_rd;
    end else begin
      t_last = '0;
    end
    elapsed = e_now - t_last;
    fire = en && e_valid && (e_level != pad_down[e_pad])
           && (elapsed > pmd_pkg::TIME_W'(cfg.holdoff));
    endi = en && e_valid && e_last;
    new_ev.note_on  = e_level;
    new_ev.note     = pmd_pkg::NOTE_W'(cfg.root_note + pmd_pkg::NOTE_W'(e_pad));
    new_ev.velocity = e_level ? cfg.on_velocity : '0;
    new_ev.channel  = cfg.chan_num;
  end

  always_comb begin
    push         = 1'b0;
    push_last    = 1'b0;
    take_new     = 1'b0;
    p_valid_next = p_valid;
    p_final_next = p_final;
    if (en) begin
      priority if (p_valid && p_final) begin
        push         = 1'b1;
        push_last    = 1'b1;
        take_new     = fire;
        p_valid_next = fire;
        p_final_next = endi;
      end else if (p_valid) begin
        if (fire) begin
          push         = 1'b1;
          take_new     = 1'b1;
          p_final_next = endi;
        end else if (endi) begin
          push         = 1'b1;
          push_last    = 1'b1;
          p_valid_next = 1'b0;
        end
      end else begin
        take_new     = fire;
        p_valid_next = fire;
        p_final_next = endi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_final <= 1'b0;
    end else begin
      p_valid <= p_valid_next;
      p_final <= p_final_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_new) begin
      p_ev <= new_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (en && push) begin
      out_ev   <= p_ev;
      out_last <= push_last;
    end
  end

  a_final_goes_out: assert property (@(posedge clk) disable iff (rst)
    en && p_valid && p_final |=> out_valid && out_last)
    else $error("pending final event was not delivered as last of column");

  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_final && endi && !fire |=> out_valid && out_last)
    else $error("column ended without marking its final event");

  a_off_velocity: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ev.note_on |-> out_ev.velocity == '0)
    else $error("note-off event with nonzero velocity");

  a_sequencer_idles: assert property (@(posedge clk) disable iff (rst)
    issue && last_row && !q_valid |=> !busy)
    else $error("row sequencer stayed busy past its last row");

endmodule
